>>> design/dndm_pkg.sv
// Shared constants, codes and types of the depth neighbor difference mask.
package dndm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DEPTH_BITS = 16;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int LIMIT_W    = 19;
  localparam int SUM_W      = 19;
  localparam int PART_W     = 18;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int NB_COUNT   = 8;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_LIMIT   = 2'd2;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 11'd480;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 19'd1000;
  localparam logic [DIM_W-1:0]   DIM_MIN      = 11'd3;

  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [COORD_W-1:0]    coord_t;

  // One complete 3x3 window: the centre and its eight neighbors.
  typedef struct packed {
    coord_t                    row;
    coord_t                    col;
    depth_t                    centre;
    depth_t [NB_COUNT-1:0]     nb;
  } win_item_t;

endpackage

>>> design/dndm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dndm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/dndm_front.sv
// Front end: position counters, line stores and the 3x3 window register.
module dndm_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  dndm_pkg::depth_t        depth,
  input  logic                    frame_start,
  input  logic [dndm_pkg::DIM_W-1:0] w_eff,
  input  logic [dndm_pkg::DIM_W-1:0] h_eff,
  output logic                    win_push,
  output dndm_pkg::win_item_t     win_item,
  input  logic                    win_full
);
  import dndm_pkg::*;

  coord_t row_cnt;
  coord_t col_cnt;
  coord_t row_next;
  coord_t col_next;

  logic [DIM_W-1:0] r0;
  logic [DIM_W-1:0] c0;
  logic [DIM_W-1:0] c_inc;
  logic [DIM_W-1:0] r_inc;
  coord_t           r_in;
  coord_t           c_in;

  logic   accept;
  logic   s1_valid;
  logic   s1_go;
  depth_t s1_px;
  coord_t s1_r;
  coord_t s1_c;

  logic                    fwd_hit;
  logic [2*DEPTH_BITS-1:0] fwd_data;
  logic [2*DEPTH_BITS-1:0] rdata;
  logic [2*DEPTH_BITS-1:0] line_eff;
  logic [2*DEPTH_BITS-1:0] wdata;
  depth_t                  top;
  depth_t                  mid;
  depth_t                  win [6];
  logic                    emit;

  assign s1_go  = s1_valid && !win_full;
  assign full   = s1_valid && !s1_go;
  assign accept = push && !full;

  // Position of the incoming pixel, with wrapping for counters past a bound.
  always_comb begin
    r0 = frame_start ? '0 : {1'b0, row_cnt};
    c0 = frame_start ? '0 : {1'b0, col_cnt};
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + 1'b1;
    end
    if (r0 >= h_eff) begin
      r0 = '0;
    end
    r_in  = r0[COORD_W-1:0];
    c_in  = c0[COORD_W-1:0];
    c_inc = {1'b0, c_in} + 1'b1;
    r_inc = {1'b0, r_in} + 1'b1;
    if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = (r_inc >= h_eff) ? '0 : r_inc[COORD_W-1:0];
    end else begin
      col_next = c_inc[COORD_W-1:0];
      row_next = r_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        row_cnt  <= row_next;
        col_cnt  <= col_next;
        // The line entry leaving stage one this cycle is not yet in the RAM.
        fwd_hit  <= s1_go && (c_in == s1_c);
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px    <= depth;
      s1_r     <= r_in;
      s1_c     <= c_in;
      fwd_data <= wdata;
    end
  end

  // Each entry holds the two rows above the incoming one: {older, newer}.
  dndm_ram #(
    .WIDTH(2 * DEPTH_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_go),
    .waddr(s1_c[ADDR_W-1:0]),
    .wdata(wdata),
    .re   (accept),
    .raddr(c_in[ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign line_eff = fwd_hit ? fwd_data : rdata;
  assign top      = line_eff[2*DEPTH_BITS-1:DEPTH_BITS];
  assign mid      = line_eff[DEPTH_BITS-1:0];
  assign wdata    = {mid, s1_px};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_go) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s1_px;
    end
  end

  assign emit     = (s1_r >= COORD_W'(2)) && (s1_c >= COORD_W'(2));
  assign win_push = s1_go && emit;

  always_comb begin
    win_item.row    = s1_r - 1'b1;
    win_item.col    = s1_c - 1'b1;
    win_item.centre = win[4];
    win_item.nb[0]  = win[0];
    win_item.nb[1]  = win[3];
    win_item.nb[2]  = top;
    win_item.nb[3]  = win[1];
    win_item.nb[4]  = mid;
    win_item.nb[5]  = win[2];
    win_item.nb[6]  = win[5];
    win_item.nb[7]  = s1_px;
  end

endmodule

>>> design/dndm_queue.sv
// Short queue of complete windows between the front end and the back end.
module dndm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  dndm_pkg::win_item_t wr_item,
  output logic                q_full,
  input  logic                rd,
  output dndm_pkg::win_item_t rd_item,
  output logic                q_empty
);
  import dndm_pkg::*;

  win_item_t            slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign q_full  = (count == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (count == '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

>>> design/dndm_back.sv
// Back end: difference terms, adder tree, threshold compare and result register.
module dndm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  dndm_pkg::win_item_t          head,
  input  logic                         head_valid,
  output logic                         head_take,
  input  logic [dndm_pkg::LIMIT_W-1:0] diff_limit,
  output logic                         empty,
  input  logic                         pop,
  output dndm_pkg::coord_t             row,
  output dndm_pkg::coord_t             col,
  output logic [dndm_pkg::SUM_W-1:0]   diff_sum,
  output logic                         mark
);
  import dndm_pkg::*;

  logic   a_valid;
  coord_t a_row;
  coord_t a_col;
  depth_t a_term [NB_COUNT];

  logic              b_valid;
  coord_t            b_row;
  coord_t            b_col;
  logic [PART_W-1:0] b_lo;
  logic [PART_W-1:0] b_hi;

  logic              o_valid;
  logic [SUM_W-1:0]  sum_c;

  logic   rdy_o;
  logic   rdy_b;
  logic   rdy_a;
  depth_t term [NB_COUNT];

  assign rdy_o     = !o_valid || pop;
  assign rdy_b     = !b_valid || rdy_o;
  assign rdy_a     = !a_valid || rdy_b;
  assign head_take = head_valid && rdy_a;
  assign empty     = !o_valid;

  // A zero neighbor adds nothing, and a zero centre leaves the sum at zero.
  always_comb begin
    for (int i = 0; i < NB_COUNT; i++) begin
      if (head.centre == '0 || head.nb[i] == '0) begin
        term[i] = '0;
      end else if (head.centre >= head.nb[i]) begin
        term[i] = head.centre - head.nb[i];
      end else begin
        term[i] = head.nb[i] - head.centre;
      end
    end
  end

  assign sum_c = SUM_W'(b_lo) + SUM_W'(b_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_valid <= head_valid;
      end
      if (rdy_b) begin
        b_valid <= a_valid;
      end
      if (rdy_o) begin
        o_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      a_row <= head.row;
      a_col <= head.col;
      for (int i = 0; i < NB_COUNT; i++) begin
        a_term[i] <= term[i];
      end
    end
    if (rdy_b && a_valid) begin
      b_row <= a_row;
      b_col <= a_col;
      b_lo  <= PART_W'(a_term[0]) + PART_W'(a_term[1])
             + PART_W'(a_term[2]) + PART_W'(a_term[3]);
      b_hi  <= PART_W'(a_term[4]) + PART_W'(a_term[5])
             + PART_W'(a_term[6]) + PART_W'(a_term[7]);
    end
    if (rdy_o && b_valid) begin
      row      <= b_row;
      col      <= b_col;
      diff_sum <= sum_c;
      mark     <= (sum_c != '0) && (sum_c < diff_limit);
    end
  end

endmodule

>>> design/depth_neighbor_difference_mask_top.sv
// Top level of the depth neighbor difference mask: configuration and block wiring.
//
// Depth pixels enter in raster order through push/full, one per clock when the
// result side keeps up. For each interior pixel the block sums the absolute
// depth differences to its nonzero neighbors and marks it when that sum is
// nonzero and below diff_limit. A result appears once the lower-right neighbor
// has arrived; border pixels produce none. The front end holds each pixel in
// stage one for the line RAM read, the window queue registers each window and
// the back end adds three pipeline stages before the result reaches the output.
// The line RAM holds no meaningful data after reset and needs no clearing pass.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// no pixels are in flight (not enforced); width and height saturate to the range 3 to 1024.
module depth_neighbor_difference_mask_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dndm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dndm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              push,
  output logic                              full,
  input  dndm_pkg::depth_t                  depth,
  input  logic                              frame_start,
  output logic                              empty,
  input  logic                              pop,
  output dndm_pkg::coord_t                  row,
  output dndm_pkg::coord_t                  col,
  output logic [dndm_pkg::SUM_W-1:0]        diff_sum,
  output logic                              mark
);
  import dndm_pkg::*;

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [LIMIT_W-1:0] diff_limit;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;

  logic      win_push;
  logic      win_full;
  win_item_t win_item;
  win_item_t head;
  logic      q_empty;
  logic      head_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      diff_limit   <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_DIFF_LIMIT:   diff_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  dndm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .depth      (depth),
    .frame_start(frame_start),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .win_push   (win_push),
    .win_item   (win_item),
    .win_full   (win_full)
  );

  dndm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (win_push),
    .wr_item(win_item),
    .q_full (win_full),
    .rd     (head_take),
    .rd_item(head),
    .q_empty(q_empty)
  );

  dndm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(!q_empty),
    .head_take (head_take),
    .diff_limit(diff_limit),
    .empty     (empty),
    .pop       (pop),
    .row       (row),
    .col       (col),
    .diff_sum  (diff_sum),
    .mark      (mark)
  );

endmodule
